// File: rtl/srat_pkg.sv
// Shared types and constants of the segment region address translator.
package srat_pkg;

    localparam int REGIONS = 16;
    localparam int IW = $clog2(REGIONS);
    localparam int CW = $clog2(REGIONS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_ADD       = 2'd1,
        OP_FINISH    = 2'd2,
        OP_TRANSLATE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_TRANSLATED = 3'd0,
        ST_NO_REGION  = 3'd1,
        ST_NOT_BACKED = 3'd2,
        ST_ACCEPTED   = 3'd3,
        ST_FULL       = 3'd4,
        ST_OVERLAP    = 3'd5,
        ST_CLEAN      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] span;
        logic [63:0] fstart;
        logic [63:0] flen;
    } region_t;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctrl_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] xlat_offset;
        logic [63:0] ostart;
        logic [63:0] ospan;
        logic [63:0] fstart;
        logic        last;
    } result_t;

endpackage

// File: rtl/srat_cell.sv
// One table cell: holds a region, inserts in sorted order and rotates along the ring.
module srat_cell
    import srat_pkg::*;
(
    input  logic         aclk,
    input  cell_ctrl_t   ctrl,
    input  logic [IW-1:0] idx,
    input  logic [CW-1:0] count,
    input  region_t      new_region,
    input  region_t      left_region,
    input  region_t      right_region,
    input  logic         left_gt,
    output logic         gt,
    output region_t      region
);

    region_t region_reg;
    region_t region_next;

    assign gt = (CW'(idx) < count) && (region_reg.start > new_region.start);
    assign region = region_reg;

    always_comb begin
        region_next = region_reg;
        if (ctrl.rot) begin
            region_next = right_region;
        end else if (ctrl.ins) begin
            // Entries above the insert point move up by one cell.
            if (left_gt) begin
                region_next = left_region;
            end else if (gt || (CW'(idx) == count)) begin
                region_next = new_region;
            end
        end
    end

    always_ff @(posedge aclk) begin
        region_reg <= region_next;
    end

endmodule

// File: rtl/srat_chain.sv
// Ring of table cells with cell zero as the read head.
module srat_chain
    import srat_pkg::*;
(
    input  logic          aclk,
    input  cell_ctrl_t    ctrl,
    input  logic [CW-1:0] count,
    input  region_t       new_region,
    output region_t       head
);

    region_t regions [REGIONS];
    logic    gts     [REGIONS];

    genvar i;
    generate
        for (i = 0; i < REGIONS; i++) begin : g_cell
            srat_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .idx         (IW'(i)),
                .count       (count),
                .new_region  (new_region),
                .left_region (regions[(i + REGIONS - 1) % REGIONS]),
                .right_region(regions[(i + 1) % REGIONS]),
                .left_gt     ((i == 0) ? 1'b0 : gts[(i + REGIONS - 1) % REGIONS]),
                .gt          (gts[i]),
                .region      (regions[i])
            );
        end
    endgenerate

    assign head = regions[0];

endmodule

// File: rtl/segment_region_address_translator_core.sv
// Top level of the segment region address translator.
// Requests arrive on the s_ channel (valid/ready) with an opcode and segment
// fields; results leave on the m_ channel, m_last marking the final result of
// a request. Clear and add each give one result, registered in the cycle
// after the request is taken. Finish and translate rotate the ring of REGIONS
// cells once past the read head, one cell per cycle while a finish scan is
// not paused, then flush the held result. Finish gives one result per
// overlapping adjacent pair or one clean result; translate gives one result.
// One request is worked on at a time; a new request is taken once the block
// is idle and the output register is empty or being emptied.
// A stalled receiver holds the output register; a finish scan then pauses
// the ring until the pending overlap result can be handed over.
// Reset empties the table, forgets the load address and drops any result.
// Table cells hold no reset value; only entries below the count are read.
module segment_region_address_translator_core
    import srat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_address,
    input  logic [63:0] s_span,
    input  logic [63:0] s_file_start,
    input  logic [63:0] s_file_length,
    input  logic        s_is_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [63:0] m_xlat_offset,
    output logic [63:0] m_overlap_start,
    output logic [63:0] m_overlap_span,
    output logic [63:0] m_following_start,
    output logic [63:0] m_load_address,
    output logic        m_load_known,
    output logic [4:0]  m_table_count,
    output logic        m_last
);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   text_reg, text_next;
    logic          seen_reg, seen_next;
    logic          mvalid_reg, mvalid_next;
    result_t       out_reg, out_next;
    result_t       pend_reg, pend_next;
    logic          pvalid_reg, pvalid_next;
    logic [IW-1:0] k_reg, k_next;
    opcode_t       op_reg, op_next;
    logic [63:0]   addr_reg, addr_next;
    logic [63:0]   pstart_reg, pstart_next;
    logic [63:0]   pspan_reg, pspan_next;
    logic [63:0]   pend_end_reg, pend_end_next;

    cell_ctrl_t ctrl;
    region_t    new_region;
    region_t    head;
    logic       out_free;
    logic       accept;
    logic       adv;
    logic       in_tab;
    logic [63:0] off;
    logic       hit;
    logic       found;

    srat_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .new_region(new_region),
        .head      (head)
    );

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign new_region.start  = s_address;
    assign new_region.span   = s_span;
    assign new_region.fstart = s_file_start;
    assign new_region.flen   = s_file_length;

    assign in_tab = CW'(k_reg) < count_reg;
    assign off    = addr_reg - head.start;
    assign hit    = (addr_reg >= head.start) && (off < head.span);
    assign found  = (k_reg != '0) && in_tab && (pend_end_reg > head.start);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        text_next     = text_reg;
        seen_next     = seen_reg;
        mvalid_next   = mvalid_reg && !m_ready;
        out_next      = out_reg;
        pend_next     = pend_reg;
        pvalid_next   = pvalid_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        pstart_next   = pstart_reg;
        pspan_next    = pspan_reg;
        pend_end_next = pend_end_reg;
        ctrl          = '0;
        adv           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    out_next.status = ST_ACCEPTED;
                    case (opcode_t'(s_opcode))
                        OP_CLEAR: begin
                            count_next  = '0;
                            text_next   = '0;
                            seen_next   = 1'b0;
                            mvalid_next = 1'b1;
                        end
                        OP_ADD: begin
                            if (s_is_text && !seen_reg) begin
                                text_next = s_address;
                                seen_next = 1'b1;
                            end
                            if (!(s_file_length == '0 && s_span != '0)) begin
                                if (count_reg == CW'(REGIONS)) begin
                                    out_next.status = ST_FULL;
                                end else begin
                                    ctrl.ins   = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            mvalid_next = 1'b1;
                        end
                        default: begin
                            op_next     = opcode_t'(s_opcode);
                            addr_next   = s_address;
                            k_next      = '0;
                            pvalid_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (op_reg == OP_TRANSLATE) begin
                    adv = 1'b1;
                    if (in_tab && !pvalid_reg && hit) begin
                        pvalid_next = 1'b1;
                        pend_next   = '0;
                        if (off < head.flen) begin
                            pend_next.status      = ST_TRANSLATED;
                            pend_next.xlat_offset = head.fstart + off;
                        end else begin
                            pend_next.status = ST_NOT_BACKED;
                        end
                    end
                end else begin
                    adv = !(found && pvalid_reg) || out_free;
                    if (adv && found) begin
                        if (pvalid_reg) begin
                            out_next    = pend_reg;
                            mvalid_next = 1'b1;
                        end
                        pvalid_next               = 1'b1;
                        pend_next                 = '0;
                        pend_next.status          = ST_OVERLAP;
                        pend_next.ostart          = pstart_reg;
                        pend_next.ospan           = pspan_reg;
                        pend_next.fstart          = head.start;
                    end
                    if (adv) begin
                        pstart_next   = head.start;
                        pspan_next    = head.span;
                        pend_end_next = head.start + head.span;
                    end
                end
                if (adv) begin
                    ctrl.rot = 1'b1;
                    k_next   = k_reg + 1'b1;
                    if (k_reg == IW'(REGIONS - 1)) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    if (pvalid_reg) begin
                        out_next = pend_reg;
                    end else begin
                        out_next = '0;
                        out_next.status = (op_reg == OP_TRANSLATE) ? ST_NO_REGION : ST_CLEAN;
                    end
                    out_next.last = 1'b1;
                    mvalid_next   = 1'b1;
                    pvalid_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            text_reg   <= '0;
            seen_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            pvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            text_reg   <= text_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
            pvalid_reg <= pvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        pend_reg     <= pend_next;
        k_reg        <= k_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        pstart_reg   <= pstart_next;
        pspan_reg    <= pspan_next;
        pend_end_reg <= pend_end_next;
    end

    assign m_valid           = mvalid_reg;
    assign m_status          = out_reg.status;
    assign m_xlat_offset     = out_reg.xlat_offset;
    assign m_overlap_start   = out_reg.ostart;
    assign m_overlap_span    = out_reg.ospan;
    assign m_following_start = out_reg.fstart;
    assign m_last            = out_reg.last;
    assign m_load_address    = text_reg;
    assign m_load_known      = seen_reg;
    assign m_table_count     = 5'(count_reg);

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("request taken while a scan is running");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(REGIONS))
        else $error("region count beyond table size");
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && adv && k_reg == IW'(REGIONS - 1)) |=> (state_reg == S_FLUSH))
        else $error("ring rotation did not end in flush");
    a_flush_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && out_free) |=> (m_valid && m_last))
        else $error("flush did not present a final result");
`endif

endmodule
